// ===== hw/rtl/dwips_pkg.sv =====
// Package for the dual wheel PI speed controller: widths, register codes, wheel update.
`default_nettype none
package dwips_pkg;

	localparam int CountW = 14;   // encoder count / target width
	localparam int GainW  = 10;   // gain width
	localparam int LimW   = 14;   // duty limit and magnitude width
	localparam int ErrW   = 15;   // error and duty state width
	localparam int DiffW  = 16;   // change of error width
	localparam int ProdW  = 27;   // gain times difference
	localparam int SumW   = 28;   // full duty sum before clamp
	localparam int IdxW   = 3;    // configuration index width

	localparam logic [LimW-1:0] LimitReset = 14'd5000;

	typedef enum logic [IdxW-1:0] {
		REG_TARGET_L = 3'd0,
		REG_TARGET_R = 3'd1,
		REG_KP_L     = 3'd2,
		REG_KI_L     = 3'd3,
		REG_KP_R     = 3'd4,
		REG_KI_R     = 3'd5,
		REG_LIMIT    = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic signed [CountW-1:0] target;
		logic [GainW-1:0]         kp;
		logic [GainW-1:0]         ki;
	} wheel_cfg_t;

	typedef struct packed {
		logic signed [ErrW-1:0] err;
		logic signed [ErrW-1:0] duty;
	} wheel_upd_t;

	// one incremental PI step, clamped to +/- limit
	function automatic wheel_upd_t wheel_update(
		input wheel_cfg_t             cfg,
		input logic signed [ErrW-1:0] speed,
		input logic signed [ErrW-1:0] prev_err,
		input logic signed [ErrW-1:0] prev_duty,
		input logic [LimW-1:0]        limit
	);
		wheel_upd_t              r;
		logic signed [ErrW-1:0]  err;
		logic signed [DiffW-1:0] diff;
		logic signed [GainW:0]   kp_s;
		logic signed [GainW:0]   ki_s;
		logic signed [ProdW-1:0] p_term;
		logic signed [ProdW-1:0] i_term;
		logic signed [SumW-1:0]  sum;
		logic signed [SumW-1:0]  lim_p;
		logic signed [SumW-1:0]  lim_n;
		logic signed [SumW-1:0]  clamped;
		err     = ErrW'({cfg.target[CountW-1], cfg.target}) - speed;
		diff    = DiffW'({err[ErrW-1], err}) - DiffW'({prev_err[ErrW-1], prev_err});
		kp_s    = {1'b0, cfg.kp};
		ki_s    = {1'b0, cfg.ki};
		p_term  = diff * kp_s;
		i_term  = err * ki_s;
		sum     = SumW'({{(SumW-ErrW){prev_duty[ErrW-1]}}, prev_duty})
			+ SumW'({p_term[ProdW-1], p_term})
			+ SumW'({i_term[ProdW-1], i_term});
		lim_p   = SumW'({{(SumW-LimW){1'b0}}, limit});
		lim_n   = -lim_p;
		if (sum > lim_p) begin
			clamped = lim_p;
		end else if (sum < lim_n) begin
			clamped = lim_n;
		end else begin
			clamped = sum;
		end
		r.err  = err;
		r.duty = clamped[ErrW-1:0];
		return r;
	endfunction

	// absolute value of a clamped duty; always fits the magnitude width
	function automatic logic [LimW-1:0] duty_mag(input logic signed [ErrW-1:0] d);
		logic signed [ErrW-1:0] a;
		a = d[ErrW-1] ? -d : d;
		return a[LimW-1:0];
	endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/dual_wheel_incremental_pi_speed_top.sv =====
// Top level of the dual wheel incremental PI speed controller.
// The input register loads at the accepting edge, the result register when its slot is free
// or draining. Throughput: one request per cycle while out_ready is high; once both registers
// hold a request, in_ready follows out_ready combinationally, so a stalled receiver holds off
// the input after two requests.
// Requests with run_enable low are taken and dropped: no result, no state change.
// Reset (arst_n low, asynchronous): state, targets, gains and valid flags zero, duty_limit 5000.
`default_nettype none
module dual_wheel_incremental_pi_speed_top (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// configuration write channel
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [dwips_pkg::IdxW-1:0]        cfg_index,
	input  wire logic [dwips_pkg::LimW-1:0]        cfg_data,
	// input request channel
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic signed [dwips_pkg::CountW-1:0] count_left,
	input  wire logic signed [dwips_pkg::CountW-1:0] count_right,
	input  wire logic                              run_enable,
	// result channel
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic                                   left_dir_pin,
	output logic [dwips_pkg::LimW-1:0]             left_magnitude,
	output logic                                   right_dir_pin,
	output logic [dwips_pkg::LimW-1:0]             right_magnitude
);

	// configuration registers
	dwips_pkg::wheel_cfg_t            cfg_l_q, cfg_r_q;
	logic [dwips_pkg::LimW-1:0]       limit_q;

	// controller state
	logic signed [dwips_pkg::ErrW-1:0] prev_err_l_q, prev_err_r_q;
	logic signed [dwips_pkg::ErrW-1:0] prev_duty_l_q, prev_duty_r_q;

	// input stage: only run-mode requests become valid here
	logic                                valid_s1;
	logic signed [dwips_pkg::CountW-1:0] count_l_s1, count_r_s1;

	// result register
	logic                              out_valid_q;
	logic                              left_dir_q, right_dir_q;
	logic [dwips_pkg::LimW-1:0]        left_mag_q, right_mag_q;

	logic                              in_fire, advance;
	logic signed [dwips_pkg::ErrW-1:0] speed_l, speed_r;
	dwips_pkg::wheel_upd_t             upd_l, upd_r;

	assign cfg_ready = 1'b1;

	// stage 1 moves into the result register whenever that slot is free or draining
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;
	assign in_fire  = in_valid && in_ready;

	// right count is negated; -8192 becomes +8192, which fits 15 bits
	assign speed_l = {count_l_s1[dwips_pkg::CountW-1], count_l_s1};
	assign speed_r = dwips_pkg::ErrW'(0) - {count_r_s1[dwips_pkg::CountW-1], count_r_s1};

	always_comb begin
		upd_l = dwips_pkg::wheel_update(cfg_l_q, speed_l, prev_err_l_q, prev_duty_l_q, limit_q);
		upd_r = dwips_pkg::wheel_update(cfg_r_q, speed_r, prev_err_r_q, prev_duty_r_q, limit_q);
	end

	// configuration writes; indexes past the list are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_l_q <= '0;
			cfg_r_q <= '0;
			limit_q <= dwips_pkg::LimitReset;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				dwips_pkg::REG_TARGET_L: cfg_l_q.target <= cfg_data;
				dwips_pkg::REG_TARGET_R: cfg_r_q.target <= cfg_data;
				dwips_pkg::REG_KP_L:     cfg_l_q.kp     <= cfg_data[dwips_pkg::GainW-1:0];
				dwips_pkg::REG_KI_L:     cfg_l_q.ki     <= cfg_data[dwips_pkg::GainW-1:0];
				dwips_pkg::REG_KP_R:     cfg_r_q.kp     <= cfg_data[dwips_pkg::GainW-1:0];
				dwips_pkg::REG_KI_R:     cfg_r_q.ki     <= cfg_data[dwips_pkg::GainW-1:0];
				dwips_pkg::REG_LIMIT:    limit_q        <= cfg_data;
				default: ;
			endcase
		end
	end

	// input stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid && run_enable;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			count_l_s1 <= count_left;
			count_r_s1 <= count_right;
		end
	end

	// state updates together with the result load
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_err_l_q  <= '0;
			prev_err_r_q  <= '0;
			prev_duty_l_q <= '0;
			prev_duty_r_q <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (advance) begin
				prev_err_l_q  <= upd_l.err;
				prev_err_r_q  <= upd_r.err;
				prev_duty_l_q <= upd_l.duty;
				prev_duty_r_q <= upd_r.duty;
				out_valid_q   <= 1'b1;
			end else if (out_ready) begin
				out_valid_q   <= 1'b0;
			end
		end
	end

	// result payload; right direction pin is inverted
	always_ff @(posedge clk) begin
		if (advance) begin
			left_dir_q  <= ~upd_l.duty[dwips_pkg::ErrW-1];
			left_mag_q  <= dwips_pkg::duty_mag(upd_l.duty);
			right_dir_q <= upd_r.duty[dwips_pkg::ErrW-1];
			right_mag_q <= dwips_pkg::duty_mag(upd_r.duty);
		end
	end

	assign out_valid       = out_valid_q;
	assign left_dir_pin    = left_dir_q;
	assign left_magnitude  = left_mag_q;
	assign right_dir_pin   = right_dir_q;
	assign right_magnitude = right_mag_q;

endmodule
`default_nettype wire

// ===== dv/testbench.sv =====
// Self-checking testbench for the dual wheel incremental PI speed controller.
module testbench;

	// Wait margin for a taken request to reach the result side.
	localparam int LatencyCycles = 2;
	// Receiver hold for the back-pressure test, in cycles.
	localparam int HoldCycles = 300;
	// Cycles with no handshake on any channel before the run is declared hung.
	localparam int QuietLimit = 2000;
	// Index past the last register; the block must ignore writes to it.
	localparam logic [dwips_pkg::IdxW-1:0] RegSpare = 3'd7;

	// One expected result: direction pins and duty magnitudes for both wheels.
	typedef struct packed {
		logic                       left_dir;
		logic [dwips_pkg::LimW-1:0] left_mag;
		logic                       right_dir;
		logic [dwips_pkg::LimW-1:0] right_mag;
	} duty_cmd_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                                cfg_valid = 1'b0;
	logic                                cfg_ready;
	logic [dwips_pkg::IdxW-1:0]          cfg_index = '0;
	logic [dwips_pkg::LimW-1:0]          cfg_data = '0;
	logic                                in_valid = 1'b0;
	logic                                in_ready;
	logic signed [dwips_pkg::CountW-1:0] count_left = '0;
	logic signed [dwips_pkg::CountW-1:0] count_right = '0;
	logic                                run_enable = 1'b0;
	logic                                out_valid;
	logic                                out_ready = 1'b0;
	logic                                left_dir_pin;
	logic [dwips_pkg::LimW-1:0]          left_magnitude;
	logic                                right_dir_pin;
	logic [dwips_pkg::LimW-1:0]          right_magnitude;

	// Predictor copy of the registers and the per-wheel history (0 = left, 1 = right).
	logic signed [dwips_pkg::CountW-1:0] wheel_target [2];
	logic [dwips_pkg::GainW-1:0]         kp_gain [2];
	logic [dwips_pkg::GainW-1:0]         ki_gain [2];
	logic [dwips_pkg::LimW-1:0]          duty_cap;
	logic signed [dwips_pkg::ErrW-1:0]   last_err [2];
	logic signed [dwips_pkg::ErrW-1:0]   last_duty [2];

	duty_cmd_t pending_cmds [$];

	int send_idle_pct = 0;   // chance per cycle that the sender idles
	int recv_stall_pct = 0;  // chance per cycle that the receiver stalls
	int hold_cycles = 0;     // long receiver hold, counted down by the receiver
	int quiet_cycles = 0;
	int mismatches = 0;
	int ticks_sent = 0;
	int ticks_dropped = 0;
	int results_seen = 0;
	int reg_writes = 0;

	dual_wheel_incremental_pi_speed_top dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.count_left      (count_left),
		.count_right     (count_right),
		.run_enable      (run_enable),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.left_dir_pin    (left_dir_pin),
		.left_magnitude  (left_magnitude),
		.right_dir_pin   (right_dir_pin),
		.right_magnitude (right_magnitude)
	);

	always #2 clk = ~clk;

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	// Registers and history as they are right after reset.
	task automatic reset_model();
		for (int w = 0; w < 2; w++) begin
			wheel_target[w] = '0;
			kp_gain[w] = '0;
			ki_gain[w] = '0;
			last_err[w] = '0;
			last_duty[w] = '0;
		end
		duty_cap = dwips_pkg::LimitReset;
	endtask

	// One incremental PI step for wheel w. All math is 64-bit so nothing wraps;
	// the clamp bounds the duty within the 15-bit history.
	function automatic longint pi_update(input int w, input longint speed);
		longint err;
		longint duty;
		longint cap;
		longint prev_e;
		longint prev_d;
		longint kp;
		longint ki;
		err = longint'(wheel_target[w]);
		err = err - speed;
		prev_e = longint'(last_err[w]);
		prev_d = longint'(last_duty[w]);
		kp = longint'(kp_gain[w]);
		ki = longint'(ki_gain[w]);
		cap = longint'(duty_cap);
		duty = prev_d + kp * (err - prev_e) + ki * err;
		if (duty > cap) begin
			duty = cap;
		end else if (duty < -cap) begin
			duty = -cap;
		end
		last_err[w] = err[dwips_pkg::ErrW-1:0];
		last_duty[w] = duty[dwips_pkg::ErrW-1:0];
		return duty;
	endfunction

	function automatic logic [dwips_pkg::LimW-1:0] magnitude_of(input longint d);
		longint a;
		a = (d < 0) ? -d : d;
		return a[dwips_pkg::LimW-1:0];
	endfunction

	// ------------------------------------------------------------------
	// Drivers
	// ------------------------------------------------------------------

	// Register write. cfg_valid is left high so back-to-back writes need no
	// drop; the caller lowers it after the last one.
	task automatic write_reg(input logic [dwips_pkg::IdxW-1:0] idx, input int data);
		logic [dwips_pkg::LimW-1:0] word;
		word = dwips_pkg::LimW'(data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= word;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		reg_writes++;
		case (idx)
			dwips_pkg::REG_TARGET_L: wheel_target[0] = word;
			dwips_pkg::REG_TARGET_R: wheel_target[1] = word;
			dwips_pkg::REG_KP_L:     kp_gain[0] = word[dwips_pkg::GainW-1:0];
			dwips_pkg::REG_KI_L:     ki_gain[0] = word[dwips_pkg::GainW-1:0];
			dwips_pkg::REG_KP_R:     kp_gain[1] = word[dwips_pkg::GainW-1:0];
			dwips_pkg::REG_KI_R:     ki_gain[1] = word[dwips_pkg::GainW-1:0];
			dwips_pkg::REG_LIMIT:    duty_cap = word;
			default: ;
		endcase
	endtask

	// Stop sending, wait for every expected result, then let the pipe empty
	// of dropped (run low) requests too.
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_cmds.size() != 0) @(posedge clk);
		repeat (LatencyCycles + 2) @(posedge clk);
	endtask

	task automatic program_regs(
		input int tl,
		input int tr,
		input int kpl,
		input int kil,
		input int kpr,
		input int kir,
		input int lim
	);
		wait_drained();
		write_reg(dwips_pkg::REG_TARGET_L, tl);
		write_reg(dwips_pkg::REG_TARGET_R, tr);
		write_reg(dwips_pkg::REG_KP_L, kpl);
		write_reg(dwips_pkg::REG_KI_L, kil);
		write_reg(dwips_pkg::REG_KP_R, kpr);
		write_reg(dwips_pkg::REG_KI_R, kir);
		write_reg(dwips_pkg::REG_LIMIT, lim);
		cfg_valid <= 1'b0;
	endtask

	// Send one control tick. in_valid stays high on return so the next tick can
	// follow in the same step; it drops while the sender idles or wait_drained stops sending.
	task automatic send_tick(input int cl, input int cr, input logic run);
		logic signed [dwips_pkg::CountW-1:0] cl_w;
		logic signed [dwips_pkg::CountW-1:0] cr_w;
		longint sl;
		longint sr;
		longint dl;
		longint dr;
		duty_cmd_t cmd;
		cl_w = dwips_pkg::CountW'(cl);
		cr_w = dwips_pkg::CountW'(cr);
		while (int'($urandom_range(99)) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		count_left <= cl_w;
		count_right <= cr_w;
		run_enable <= run;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		ticks_sent++;
		if (run) begin
			sl = longint'(cl_w);
			sr = longint'(cr_w);
			sr = -sr;   // right encoder counts the other way
			dl = pi_update(0, sl);
			dr = pi_update(1, sr);
			cmd.left_dir = (dl >= 0);
			cmd.left_mag = magnitude_of(dl);
			cmd.right_dir = (dr < 0);   // right pin is inverted
			cmd.right_mag = magnitude_of(dr);
			pending_cmds.push_back(cmd);
		end else begin
			ticks_dropped++;
		end
	endtask

	// ------------------------------------------------------------------
	// Random values
	// ------------------------------------------------------------------

	function automatic int pick_target();
		logic signed [dwips_pkg::CountW-1:0] raw;
		raw = dwips_pkg::CountW'($urandom_range(16383, 0));
		case ($urandom_range(7))
			0: return 8191;
			1: return -8191;
			2: return -8192;
			3: return 0;
			default: return int'(raw);
		endcase
	endfunction

	// Mostly small gains so the loop stays out of the clamp for a while.
	function automatic int pick_gain();
		case ($urandom_range(9))
			0: return 0;
			1: return 1023;
			2: return int'($urandom_range(1023, 0));
			default: return int'($urandom_range(12, 0));
		endcase
	endfunction

	function automatic int pick_limit();
		case ($urandom_range(7))
			0: return 0;
			1: return 16383;
			2: return 10000;
			3: return int'($urandom_range(16383, 10001));
			default: return int'($urandom_range(10000, 1));
		endcase
	endfunction

	// Count close to the one that zeroes the error, or anything at all.
	function automatic int pick_count(input int centre);
		int v;
		logic signed [dwips_pkg::CountW-1:0] raw;
		if ($urandom_range(99) < 60) begin
			v = centre + int'($urandom_range(40, 0)) - 20;
			if (v > 8191) v = 8191;
			if (v < -8192) v = -8192;
			return v;
		end
		raw = dwips_pkg::CountW'($urandom);
		return int'(raw);
	endfunction

	task automatic send_random_tick();
		int cl_centre;
		int cr_centre;
		cl_centre = int'(wheel_target[0]);
		cr_centre = int'(wheel_target[1]);
		cr_centre = -cr_centre;
		send_tick(pick_count(cl_centre), pick_count(cr_centre), $urandom_range(9) != 0);
	endtask

	task automatic program_random_regs();
		program_regs(pick_target(), pick_target(), pick_gain(), pick_gain(),
			pick_gain(), pick_gain(), pick_limit());
	endtask

	// ------------------------------------------------------------------
	// Receiver and checker
	// ------------------------------------------------------------------

	// out_ready: random stalls, or forced low during a long hold.
	initial begin
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				out_ready <= 1'b0;
				hold_cycles--;
			end else begin
				out_ready <= (int'($urandom_range(99)) >= recv_stall_pct);
			end
		end
	end

	function automatic void check_field(input string fname, input int want, input int got);
		if (want != got) begin
			mismatches++;
			$display("%0t: %s mismatch: expected %0d, actual %0d", $time, fname, want, got);
		end
	endfunction

	always @(posedge clk) begin : check_results
		duty_cmd_t want;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (pending_cmds.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected result: expected none, actual dir %0b/%0b mag %0d/%0d",
					$time, left_dir_pin, right_dir_pin, left_magnitude, right_magnitude);
			end else begin
				want = pending_cmds.pop_front();
				check_field("left_dir_pin", int'(want.left_dir), int'(left_dir_pin));
				check_field("left_magnitude", int'(want.left_mag), int'(left_magnitude));
				check_field("right_dir_pin", int'(want.right_dir), int'(right_dir_pin));
				check_field("right_magnitude", int'(want.right_mag), int'(right_magnitude));
			end
		end
	end

	// Hang detector: any handshake on any channel resets the count.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)
				|| (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= QuietLimit) begin
			$display("%0t: no handshake for %0d cycles, %0d results outstanding",
				$time, QuietLimit, pending_cmds.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Gains reset to zero and the limit to its default: every duty stays zero.
	task automatic test_reset_state();
		send_tick(0, 0, 1'b1);
		send_tick(8191, -8192, 1'b1);
		send_tick(5, 5, 1'b0);
		send_tick(-8192, 8191, 1'b1);
		wait_drained();
	endtask

	// Count extremes, the negated right count at -8192, a dropped tick in the
	// middle of a run, and a zero error.
	task automatic test_corner_ticks();
		program_regs(100, -100, 3, 1, 2, 2, 10000);
		send_tick(0, 0, 1'b1);
		send_tick(8191, -8192, 1'b1);
		send_tick(-8192, 8191, 1'b1);
		send_tick(-8192, -8192, 1'b1);
		send_tick(8191, 8191, 1'b0);
		send_tick(-1, 1, 1'b1);
		send_tick(100, 100, 1'b1);
		send_tick(100, 100, 1'b1);
		wait_drained();
	endtask

	// Full gains against the widest errors: the sum runs far past any limit and
	// has to saturate rather than wrap. Then the narrowest limits.
	task automatic test_saturation();
		program_regs(8191, -8192, 1023, 1023, 1023, 1023, 16383);
		send_tick(-8192, -8192, 1'b1);
		send_tick(-8192, -8192, 1'b1);
		send_tick(8191, 8191, 1'b1);
		send_tick(-8192, 8191, 1'b1);
		wait_drained();
		write_reg(dwips_pkg::REG_LIMIT, 0);
		cfg_valid <= 1'b0;
		send_tick(8191, -8192, 1'b1);
		send_tick(-8192, 8191, 1'b1);
		wait_drained();
		write_reg(dwips_pkg::REG_LIMIT, 1);
		cfg_valid <= 1'b0;
		send_tick(-8192, 8191, 1'b1);
		send_tick(8191, -8192, 1'b1);
		wait_drained();
	endtask

	// A write past the last register must leave every setting alone.
	task automatic test_spare_index();
		program_regs(-300, 300, 4, 2, 5, 1, 2000);
		write_reg(RegSpare, 16383);
		cfg_valid <= 1'b0;
		send_tick(17, -4000, 1'b1);
		send_tick(-6000, 29, 1'b1);
		wait_drained();
	endtask

	// Random settings and ticks under each idle mix.
	task automatic test_random_traffic();
		int send_mix [4] = '{0, 80, 0, 18};
		int recv_mix [4] = '{0, 0, 80, 18};
		for (int p = 0; p < 4; p++) begin
			send_idle_pct = send_mix[p];
			recv_stall_pct = recv_mix[p];
			repeat (4) begin
				program_random_regs();
				repeat (55) send_random_tick();
			end
			wait_drained();
		end
		send_idle_pct = 0;
		recv_stall_pct = 0;
	endtask

	// Receiver holds off long enough for the block to fill and push back on its
	// input while ticks keep coming; then the sender waits out every result.
	task automatic test_backpressure();
		program_random_regs();
		hold_cycles = HoldCycles;
		repeat (40) send_random_tick();
		wait_drained();
		repeat (10) send_random_tick();
		wait_drained();
	endtask

	initial begin
		reset_model();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_corner_ticks();
		test_saturation();
		test_spare_index();
		test_random_traffic();
		test_backpressure();

		$display("Covered %0d ticks (%0d with run low), %0d checked results, %0d reg writes,",
			ticks_sent, ticks_dropped, results_seen, reg_writes);
		$display("with no idling, 80%% sender gaps, 80%% receiver stalls, both at 18%%, %0d-cycle hold.",
			HoldCycles);
		if (mismatches == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
